/* rtl/mhl_pkg.sv */
package mhl_pkg;

    parameter int unsigned NUM_PAIRS = 5;
    parameter int unsigned LAT_IN_W  = 20;
    parameter int unsigned LON_IN_W  = 21;
    parameter int unsigned LAT_W     = 21;
    parameter int unsigned LON_W     = 22;
    parameter int unsigned CHAR_W    = 7;
    parameter int unsigned Q_W       = 5;
    parameter int unsigned PAIRS_W   = 3;
    parameter int unsigned COUNT_W   = 4;

    parameter logic [PAIRS_W-1:0] PAIRS_DEFAULT = 3'd3;
    parameter logic [PAIRS_W-1:0] PAIRS_MIN     = 3'd1;
    parameter logic [PAIRS_W-1:0] PAIRS_MAX     = 3'd5;

    parameter logic signed [LAT_W-1:0] LAT_SPAN = 21'sd518400;
    parameter logic signed [LON_W-1:0] LON_SPAN = 22'sd1036800;

    parameter logic [LON_W-1:0] LON_STEP [NUM_PAIRS] = '{
        22'd115200, 22'd11520, 22'd480, 22'd48, 22'd2
    };
    parameter logic [LAT_W-1:0] LAT_STEP [NUM_PAIRS] = '{
        21'd57600, 21'd5760, 21'd240, 21'd24, 21'd1
    };
    parameter int unsigned Q_MAX [NUM_PAIRS] = '{18, 9, 23, 9, 23};
    parameter logic [CHAR_W-1:0] PAIR_BASE [NUM_PAIRS] = '{
        7'd65, 7'd48, 7'd97, 7'd48, 7'd97
    };

    typedef logic [NUM_PAIRS-1:0][CHAR_W-1:0] t_char_row;

    typedef struct packed {
        t_char_row lon;
        t_char_row lat;
    } t_chars;

    typedef struct packed {
        logic [LON_W-1:0] lon;
        logic [LAT_W-1:0] lat;
        t_chars           chars;
    } t_work;

endpackage

/* rtl/mhl_clamp.sv */
module mhl_clamp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [mhl_pkg::LAT_IN_W-1:0]    i_latitude,
    input  logic signed [mhl_pkg::LON_IN_W-1:0]    i_longitude,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output mhl_pkg::t_work                         o_work
);

    logic                                  r_valid;
    mhl_pkg::t_work                        r_work;
    mhl_pkg::t_work                        n_work;
    logic signed [mhl_pkg::LAT_W-1:0]      lat_ext;
    logic signed [mhl_pkg::LON_W-1:0]      lon_ext;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        lat_ext = {i_latitude[mhl_pkg::LAT_IN_W-1], i_latitude};
        lon_ext = {i_longitude[mhl_pkg::LON_IN_W-1], i_longitude};
        n_work  = '0;
        if (lat_ext < -mhl_pkg::LAT_SPAN) begin
            n_work.lat = '0;
        end else if (lat_ext > mhl_pkg::LAT_SPAN) begin
            n_work.lat = mhl_pkg::LAT_W'(mhl_pkg::LAT_SPAN + mhl_pkg::LAT_SPAN);
        end else begin
            n_work.lat = mhl_pkg::LAT_W'(lat_ext + mhl_pkg::LAT_SPAN);
        end
        if (lon_ext < -mhl_pkg::LON_SPAN) begin
            n_work.lon = '0;
        end else if (lon_ext > mhl_pkg::LON_SPAN) begin
            n_work.lon = mhl_pkg::LON_W'(mhl_pkg::LON_SPAN + mhl_pkg::LON_SPAN);
        end else begin
            n_work.lon = mhl_pkg::LON_W'(lon_ext + mhl_pkg::LON_SPAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

/* rtl/mhl_cell.sv */
module mhl_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mhl_pkg::t_work  i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output mhl_pkg::t_work  o_work
);

    logic                       r_valid;
    mhl_pkg::t_work             r_work;
    mhl_pkg::t_work             n_work;
    logic [mhl_pkg::Q_W-1:0]    lon_q;
    logic [mhl_pkg::Q_W-1:0]    lat_q;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        lon_q = '0;
        lat_q = '0;
        for (int k = 1; k <= int'(mhl_pkg::Q_MAX[IDX]); k++) begin
            if (i_work.lon >= mhl_pkg::LON_W'(k * mhl_pkg::LON_STEP[IDX])) begin
                lon_q = mhl_pkg::Q_W'(k);
            end
            if (i_work.lat >= mhl_pkg::LAT_W'(k * mhl_pkg::LAT_STEP[IDX])) begin
                lat_q = mhl_pkg::Q_W'(k);
            end
        end
        n_work = i_work;
        n_work.lon = i_work.lon
                   - mhl_pkg::LON_W'(mhl_pkg::LON_W'(lon_q) * mhl_pkg::LON_STEP[IDX]);
        n_work.lat = i_work.lat
                   - mhl_pkg::LAT_W'(mhl_pkg::LAT_W'(lat_q) * mhl_pkg::LAT_STEP[IDX]);
        n_work.chars.lon[IDX] = mhl_pkg::PAIR_BASE[IDX] + mhl_pkg::CHAR_W'(lon_q);
        n_work.chars.lat[IDX] = mhl_pkg::PAIR_BASE[IDX] + mhl_pkg::CHAR_W'(lat_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

/* rtl/maidenhead_locator_encoder_core.sv */
// Maidenhead locator encoder.
// Input channel (i_in_valid / o_in_ready): one request carries a latitude and
// a longitude in signed units of 1/5760 degree. Values beyond +-90 / +-180
// degrees are clamped to the bound.
// Output channel (o_out_valid / i_out_ready): one result per request, ten
// ASCII characters in lon/lat pairs plus the count of characters in use.
// Pairs past the configured count read as zero.
// Config: i_cfg_we writes i_cfg_wdata into the pair count (1 to 5, other
// codes act as 3). Write it only while no request is in flight.
// Pipeline: one clamp stage loaded at the accepting edge, then a row of five
// digit cells, one per character pair, each splitting off one grid step by a
// constant compare ladder and passing the remainder on.
// Throughput: one request per cycle while the output is not stalled.
// Each stage has its own valid bit, so bubbles close up and input is still
// taken while a result waits.
// Stall: when i_out_ready is low, the result holds and stages fill behind it;
// o_in_ready drops only once all six stages are full.
// Reset: all stages empty, pair count back to 3.
module maidenhead_locator_encoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mhl_pkg::PAIRS_W-1:0]           i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [mhl_pkg::LAT_IN_W-1:0]   i_latitude,
    input  logic signed [mhl_pkg::LON_IN_W-1:0]   i_longitude,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [6:0]                            o_lon_field_char,
    output logic [6:0]                            o_lat_field_char,
    output logic [5:0]                            o_lon_square_char,
    output logic [5:0]                            o_lat_square_char,
    output logic [6:0]                            o_lon_sub_char,
    output logic [6:0]                            o_lat_sub_char,
    output logic [5:0]                            o_lon_ext_char,
    output logic [5:0]                            o_lat_ext_char,
    output logic [6:0]                            o_lon_prec_char,
    output logic [6:0]                            o_lat_prec_char,
    output logic [mhl_pkg::COUNT_W-1:0]           o_char_count
);

    logic [mhl_pkg::PAIRS_W-1:0]  r_pair_count;
    logic [mhl_pkg::PAIRS_W-1:0]  pairs;
    mhl_pkg::t_work               work  [mhl_pkg::NUM_PAIRS+1];
    logic                         valid [mhl_pkg::NUM_PAIRS+1];
    logic                         ready [mhl_pkg::NUM_PAIRS+1];
    mhl_pkg::t_char_row           lon_row;
    mhl_pkg::t_char_row           lat_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= mhl_pkg::PAIRS_DEFAULT;
        end else if (i_cfg_we) begin
            r_pair_count <= i_cfg_wdata;
        end
    end

    mhl_clamp u_clamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_latitude  (i_latitude),
        .i_longitude (i_longitude),
        .o_valid     (valid[0]),
        .i_ready     (ready[0]),
        .o_work      (work[0])
    );

    for (genvar g = 0; g < mhl_pkg::NUM_PAIRS; g++) begin : g_cell
        mhl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .o_ready (ready[g]),
            .i_work  (work[g]),
            .o_valid (valid[g+1]),
            .i_ready (ready[g+1]),
            .o_work  (work[g+1])
        );
    end

    assign ready[mhl_pkg::NUM_PAIRS] = i_out_ready;
    assign o_out_valid = valid[mhl_pkg::NUM_PAIRS];

    always_comb begin
        if (r_pair_count < mhl_pkg::PAIRS_MIN || r_pair_count > mhl_pkg::PAIRS_MAX) begin
            pairs = mhl_pkg::PAIRS_DEFAULT;
        end else begin
            pairs = r_pair_count;
        end
        for (int p = 0; p < mhl_pkg::NUM_PAIRS; p++) begin
            if (mhl_pkg::PAIRS_W'(p) < pairs) begin
                lon_row[p] = work[mhl_pkg::NUM_PAIRS].chars.lon[p];
                lat_row[p] = work[mhl_pkg::NUM_PAIRS].chars.lat[p];
            end else begin
                lon_row[p] = '0;
                lat_row[p] = '0;
            end
        end
    end

    assign o_lon_field_char  = lon_row[0];
    assign o_lat_field_char  = lat_row[0];
    assign o_lon_square_char = lon_row[1][5:0];
    assign o_lat_square_char = lat_row[1][5:0];
    assign o_lon_sub_char    = lon_row[2];
    assign o_lat_sub_char    = lat_row[2];
    assign o_lon_ext_char    = lon_row[3][5:0];
    assign o_lat_ext_char    = lat_row[3][5:0];
    assign o_lon_prec_char   = lon_row[4];
    assign o_lat_prec_char   = lat_row[4];
    assign o_char_count      = {pairs, 1'b0};

    a_count_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_count == 4'd2 || o_char_count == 4'd4 ||
                         o_char_count == 4'd6 || o_char_count == 4'd8 ||
                         o_char_count == 4'd10))
        else $error("char count not an even pair count");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lon_field_char >= 7'd65 && o_lon_field_char <= 7'd83 &&
                         o_lat_field_char >= 7'd65 && o_lat_field_char <= 7'd83))
        else $error("field letter outside A to S");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_count == 4'd2) |->
            (o_lon_square_char == 6'd0 && o_lat_square_char == 6'd0 &&
             o_lon_prec_char == 7'd0 && o_lat_prec_char == 7'd0))
        else $error("unused pair not zero");

    a_pole_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lat_field_char == 7'd83 && o_char_count >= 4'd4) |->
            (o_lat_square_char == 6'd48))
        else $error("north pole square not zero digit");

endmodule
